// File: design/wdcf_pkg.sv
// wdcf_pkg: shared constants, register codes and payload types of the
// windowed derivative crossing finder; no dependencies
`default_nettype none

package wdcf_pkg;

    // fixed widths of the payload and register fields
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 22;
    localparam int WIN_W       = 5;
    localparam int THR_W       = 20;
    localparam int TPS_W       = 8;
    localparam int CFG_W       = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int IDX_W       = 10;
    localparam int TS_W        = 18;

    // defaults for the top level parameters
    localparam int WDCF_MAX_WINDOW    = 16;
    localparam int WDCF_FRAME_SAMPLES = 1024;

    // queue depths
    localparam int IN_DEPTH  = 4;
    localparam int OUT_DEPTH = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME      = 2'd2;

    // register reset values
    localparam logic [WIN_W-1:0] WINDOW_RST    = 5'd1;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 20'd100;
    localparam logic [TPS_W-1:0] TPS_RST       = 8'd8;

    typedef enum logic [1:0] {
        KIND_UP,
        KIND_DOWN,
        KIND_DOUBLE_UP,
        KIND_DOUBLE_DOWN
    } kind_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          frame_end;
    } sample_item_t;

    typedef struct packed {
        kind_t             crossing_kind;
        logic [IDX_W-1:0]  sample_index;
        logic [TS_W-1:0]   time_stamp;
        logic              last_result;
    } result_item_t;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [THR_W-1:0] threshold;
        logic [TPS_W-1:0] time_per_sample;
    } cfg_t;

endpackage

`default_nettype wire

// File: design/windowed_derivative_crossing_finder_top.sv
// windowed_derivative_crossing_finder_top: front tagging, job queue, derivative
// back end and result queue; uses wdcf_pkg, wdcf_front, wdcf_fifo, wdcf_back
//
// Samples enter through a queue port: a transfer happens at a clock edge with
// push high and full low. Results leave through a queue port: the oldest
// result is on result_item while empty is low and is taken with pop. The
// three registers are written through cfg_write / cfg_index / cfg_data; the
// user must do so only while the block is idle, which the block does not
// enforce. The window is latched at the first sample of each frame.
// Throughput: one sample per cycle inside a frame while the result queue has
// room. At a frame end the last up to window+1 derivatives go one per cycle,
// as result queue room allows, through the shared adder tree; the four-entry
// job queue takes up to four samples meanwhile, then full holds the sender.
// A derivative is formed once the window samples after it are in; it passes
// the leaf registers, the adder tree levels and the held result register,
// held there until the next crossing or the end of its item decides its
// last_result flag. When the receiver stalls, the result queue fills and the
// back end stops issuing derivatives, then the job queue fills and full
// rises. Reset clears all control state and loads the register reset values;
// no clearing pass.
`default_nettype none

module windowed_derivative_crossing_finder_top #(
    parameter int MAX_WINDOW    = wdcf_pkg::WDCF_MAX_WINDOW,
    parameter int FRAME_SAMPLES = wdcf_pkg::WDCF_FRAME_SAMPLES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  wdcf_pkg::sample_item_t         sample_item,
    output logic                           empty,
    input  logic                           pop,
    output wdcf_pkg::result_item_t         result_item,
    input  logic                           cfg_write,
    input  logic [wdcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wdcf_pkg::CFG_W-1:0]     cfg_data
);

    import wdcf_pkg::*;

    localparam int CNT_W   = $clog2(FRAME_SAMPLES);
    localparam int ENTRY_W = SAMPLE_BITS + CNT_W + WIN_W + 1;
    localparam int OCNT_W  = $clog2(OUT_DEPTH + 1);

    cfg_t               cfg;
    logic               q_push;
    logic [ENTRY_W-1:0] q_wdata;
    logic               q_full;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_rdata;
    logic               q_pop;
    logic [OCNT_W-1:0]  o_count;
    logic               o_push;
    result_item_t       o_data;
    logic               o_full;

    // sample intake and tagging
    wdcf_front #(
        .MAX_WINDOW    (MAX_WINDOW),
        .FRAME_SAMPLES (FRAME_SAMPLES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_item (sample_item),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg         (cfg),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_full      (q_full)
    );

    // job queue between front and back
    wdcf_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (IN_DEPTH)
    ) u_job_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty),
        .count     ()
    );

    // derivative evaluation and crossing detection
    wdcf_back #(
        .MAX_WINDOW    (MAX_WINDOW),
        .FRAME_SAMPLES (FRAME_SAMPLES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .o_count (o_count),
        .o_push  (o_push),
        .o_data  (o_data)
    );

    // result queue
    wdcf_fifo #(
        .WIDTH ($bits(result_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (o_push && !o_full),
        .push_data (o_data),
        .pop       (pop),
        .pop_data  (result_item),
        .full      (o_full),
        .empty     (empty),
        .count     (o_count)
    );

endmodule

`default_nettype wire

// File: design/wdcf_fifo.sv
// wdcf_fifo: small register queue with head data shown combinationally
// no package dependency beyond default widths from wdcf_pkg
`default_nettype none

module wdcf_fifo #(
    parameter int WIDTH = $bits(wdcf_pkg::result_item_t),
    parameter int DEPTH = wdcf_pkg::OUT_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // status
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = data_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/wdcf_front.sv
// wdcf_front: configuration registers, frame position tracking and tagging
// of each accepted sample; uses wdcf_pkg
`default_nettype none

module wdcf_front #(
    parameter int MAX_WINDOW    = wdcf_pkg::WDCF_MAX_WINDOW,
    parameter int FRAME_SAMPLES = wdcf_pkg::WDCF_FRAME_SAMPLES,
    localparam int CNT_W   = $clog2(FRAME_SAMPLES),
    localparam int ENTRY_W = wdcf_pkg::SAMPLE_BITS + CNT_W + wdcf_pkg::WIN_W + 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  wdcf_pkg::sample_item_t             sample_item,
    input  logic                               cfg_write,
    input  logic [wdcf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wdcf_pkg::CFG_W-1:0]         cfg_data,
    output wdcf_pkg::cfg_t                     cfg,
    output logic                               q_push,
    output logic [ENTRY_W-1:0]                 q_data,
    input  logic                               q_full
);

    import wdcf_pkg::*;

    cfg_t             cfg_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [WIN_W-1:0] frame_win_reg, frame_win_next;
    logic [WIN_W-1:0] win_clamped;
    logic             is_end;
    logic             accept;

    assign cfg    = cfg_reg;
    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window          <= WINDOW_RST;
            cfg_reg.threshold       <= THRESHOLD_RST;
            cfg_reg.time_per_sample <= TPS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WINDOW:    cfg_reg.window          <= cfg_data[WIN_W-1:0];
                REG_THRESHOLD: cfg_reg.threshold       <= cfg_data[THR_W-1:0];
                REG_TIME:      cfg_reg.time_per_sample <= cfg_data[TPS_W-1:0];
                default:       ;
            endcase
        end
    end

    // window clamp, latched at the first sample of a frame
    always_comb
    begin
        if (cfg_reg.window == '0)
        begin
            win_clamped = WIN_W'(1);
        end
        else if (int'(cfg_reg.window) > MAX_WINDOW)
        begin
            win_clamped = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_clamped = cfg_reg.window;
        end
        frame_win_next = (count_reg == '0) ? win_clamped : frame_win_reg;
        // explicit end or overlong frame
        is_end     = sample_item.frame_end || (count_reg == CNT_W'(FRAME_SAMPLES - 1));
        count_next = is_end ? '0 : count_reg + CNT_W'(1);
    end

    // tagged sample into the job queue
    assign q_data = {sample_item.sample, count_reg, frame_win_next, is_end};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            frame_win_reg <= WINDOW_RST;
        end
        else if (accept)
        begin
            count_reg     <= count_next;
            frame_win_reg <= frame_win_next;
        end
    end

endmodule

`default_nettype wire

// File: design/wdcf_back.sv
// wdcf_back: sample delay line, derivative job sequencer, pipelined adder
// tree, threshold compare and result grouping; uses wdcf_pkg
`default_nettype none

module wdcf_back #(
    parameter int MAX_WINDOW    = wdcf_pkg::WDCF_MAX_WINDOW,
    parameter int FRAME_SAMPLES = wdcf_pkg::WDCF_FRAME_SAMPLES,
    localparam int CNT_W   = $clog2(FRAME_SAMPLES),
    localparam int ENTRY_W = wdcf_pkg::SAMPLE_BITS + CNT_W + wdcf_pkg::WIN_W + 1,
    localparam int OCNT_W  = $clog2(wdcf_pkg::OUT_DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  wdcf_pkg::cfg_t          cfg,
    input  logic                    q_empty,
    input  logic [ENTRY_W-1:0]      q_data,
    output logic                    q_pop,
    input  logic [OCNT_W-1:0]       o_count,
    output logic                    o_push,
    output wdcf_pkg::result_item_t  o_data
);

    import wdcf_pkg::*;

    localparam int LINE_DEPTH = 2 * MAX_WINDOW + 1;
    localparam int LVL        = $clog2(LINE_DEPTH);
    localparam int TREE_N     = 1 << LVL;
    localparam int ACC_W      = (SAMPLE_BITS + 1 + LVL > SUM_BITS + 1) ?
                                SAMPLE_BITS + 1 + LVL : SUM_BITS + 1;
    localparam int EXT_W      = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
    localparam int IDX_EXT    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int INF_W      = $clog2(LVL + 2);
    localparam int CR_W       = $clog2(OUT_DEPTH + LVL + 3);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SUM_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    typedef struct packed {
        logic             valid;
        logic             group_last;
        logic             first;
        logic [CNT_W-1:0] idx;
    } meta_t;

    // delay line, newest sample at tap 0
    logic signed [SAMPLE_BITS-1:0] line_reg [LINE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] shift_line [LINE_DEPTH];

    // flush sequencer
    logic             flush_reg, flush_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic [WIN_W-1:0] m_reg, m_next;

    // queue entry fields
    logic signed [SAMPLE_BITS-1:0] e_sample;
    logic [CNT_W-1:0]              e_s;
    logic [WIN_W-1:0]              e_m;
    logic                          e_end;
    logic [EXT_W-1:0]              s_x;
    logic [EXT_W-1:0]              m_x;
    logic [EXT_W-1:0]              first_x;

    // job of this cycle
    logic             credit;
    logic             pop;
    logic             issue;
    logic [CNT_W-1:0] job_i;
    logic [CNT_W-1:0] job_s;
    logic [WIN_W-1:0] job_m;
    logic             job_last;
    logic [EXT_W-1:0] i_x;
    logic [EXT_W-1:0] age_x;
    logic [WIN_W-1:0] age;
    logic [WIN_W-1:0] span;
    logic [WIN_W:0]   lo;
    logic [WIN_W:0]   hi;
    logic [CR_W-1:0]  room_used;

    // adder tree, heap order, leaves at TREE_N and up
    logic signed [ACC_W-1:0] leaf_term [TREE_N];
    logic signed [ACC_W-1:0] node_reg [1:2*TREE_N-1];
    meta_t                   meta_reg [LVL+1];
    logic [INF_W-1:0]        inflight_reg, inflight_next;

    // compare stage
    meta_t                     ev;
    logic signed [ACC_W-1:0]   root;
    logic signed [SUM_BITS-1:0] v;
    logic signed [SUM_BITS-1:0] prev_reg;
    logic signed [SUM_BITS:0]  v_w;
    logic signed [SUM_BITS:0]  p_w;
    logic signed [SUM_BITS:0]  tpos;
    logic signed [SUM_BITS:0]  tneg;
    kind_t                     kind;
    logic                      crossed;
    logic [IDX_EXT-1:0]        idx_ext;
    logic [IDX_W-1:0]          idx10;
    logic [TS_W-1:0]           ts;
    result_item_t              new_res;

    // result grouping, one held result per input item
    logic         pend_valid_reg, pend_valid_next;
    logic         pend_done_reg, pend_done_next;
    result_item_t pend_item_reg, pend_item_next;

    // unpack queue entry
    assign e_sample = q_data[ENTRY_W-1 -: SAMPLE_BITS];
    assign e_s      = q_data[WIN_W+1 +: CNT_W];
    assign e_m      = q_data[1 +: WIN_W];
    assign e_end    = q_data[0];
    assign s_x      = EXT_W'(e_s);
    assign m_x      = EXT_W'(e_m);
    assign first_x  = (s_x > m_x) ? s_x - m_x : EXT_W'(1);

    // room in the result queue for every result still in flight
    assign room_used = CR_W'(o_count) + CR_W'(inflight_reg) + CR_W'(pend_valid_reg);
    assign credit    = room_used < CR_W'(OUT_DEPTH);
    assign q_pop     = pop;

    // job sequencer
    always_comb
    begin
        pop        = 1'b0;
        issue      = 1'b0;
        job_i      = i_reg;
        job_s      = s_reg;
        job_m      = m_reg;
        job_last   = (i_reg == s_reg);
        flush_next = flush_reg;
        i_next     = i_reg;
        s_next     = s_reg;
        m_next     = m_reg;
        if (credit)
        begin
            if (flush_reg)
            begin
                issue = 1'b1;
                if (job_last)
                begin
                    flush_next = 1'b0;
                end
                else
                begin
                    i_next = i_reg + CNT_W'(1);
                end
            end
            else if (!q_empty)
            begin
                pop   = 1'b1;
                job_s = e_s;
                job_m = e_m;
                if (!e_end)
                begin
                    // derivative m samples back is complete
                    issue    = s_x > m_x;
                    job_i    = CNT_W'(s_x - m_x);
                    job_last = 1'b1;
                end
                else
                begin
                    // frame end flushes the remaining derivatives
                    issue    = (e_s != '0);
                    job_i    = CNT_W'(first_x);
                    job_last = (CNT_W'(first_x) == e_s);
                    if (issue && !job_last)
                    begin
                        flush_next = 1'b1;
                        i_next     = CNT_W'(first_x) + CNT_W'(1);
                        s_next     = e_s;
                        m_next     = e_m;
                    end
                end
            end
        end
    end

    // window extent: age of the center sample, span min(m, i, s - i)
    always_comb
    begin
        i_x   = EXT_W'(job_i);
        age_x = EXT_W'(job_s) - i_x;
        age   = age_x[WIN_W-1:0];
        span  = job_m;
        if (i_x < EXT_W'(job_m))
        begin
            span = i_x[WIN_W-1:0];
        end
        if (age < span)
        begin
            span = age;
        end
        lo = {1'b0, age} - {1'b0, span};
        hi = {1'b0, age} + {1'b0, span};
    end

    // leaf terms: newer side added, older side subtracted
    always_comb
    begin
        shift_line[0] = e_sample;
        for (int j = 1; j < LINE_DEPTH; j++)
        begin
            shift_line[j] = line_reg[j-1];
        end
        for (int j = 0; j < TREE_N; j++)
        begin
            leaf_term[j] = '0;
        end
        for (int j = 0; j < LINE_DEPTH; j++)
        begin
            if (j >= int'(lo) && j < int'(age))
            begin
                leaf_term[j] = pop ? ACC_W'(shift_line[j]) : ACC_W'(line_reg[j]);
            end
            else if (j > int'(age) && j <= int'(hi))
            begin
                leaf_term[j] = pop ? -ACC_W'(shift_line[j]) : -ACC_W'(line_reg[j]);
            end
        end
    end

    // delay line shift on each popped sample
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int j = 0; j < LINE_DEPTH; j++)
            begin
                line_reg[j] <= shift_line[j];
            end
        end
    end

    // adder tree levels
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < TREE_N; k++)
        begin
            node_reg[TREE_N + k] <= leaf_term[k];
        end
        for (int k = 1; k < TREE_N; k++)
        begin
            node_reg[k] <= node_reg[2*k] + node_reg[2*k+1];
        end
    end

    assign inflight_next = inflight_reg + INF_W'(issue) - INF_W'(meta_reg[LVL].valid);

    // sequencer and job tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_reg    <= 1'b0;
            i_reg        <= '0;
            s_reg        <= '0;
            m_reg        <= '0;
            inflight_reg <= '0;
            for (int p = 0; p <= LVL; p++)
            begin
                meta_reg[p] <= '0;
            end
        end
        else
        begin
            flush_reg    <= flush_next;
            i_reg        <= i_next;
            s_reg        <= s_next;
            m_reg        <= m_next;
            inflight_reg <= inflight_next;
            meta_reg[0]  <= '{valid: issue, group_last: job_last,
                              first: (job_i == CNT_W'(1)), idx: job_i};
            for (int p = 1; p <= LVL; p++)
            begin
                meta_reg[p] <= meta_reg[p-1];
            end
        end
    end

    // saturate and classify against the previous derivative
    always_comb
    begin
        ev   = meta_reg[LVL];
        root = node_reg[1];
        if (root > SAT_HI)
        begin
            v = SAT_HI[SUM_BITS-1:0];
        end
        else if (root < SAT_LO)
        begin
            v = SAT_LO[SUM_BITS-1:0];
        end
        else
        begin
            v = root[SUM_BITS-1:0];
        end
        v_w  = (SUM_BITS + 1)'(v);
        p_w  = ev.first ? '0 : (SUM_BITS + 1)'(prev_reg);
        tpos = signed'({{(SUM_BITS + 1 - THR_W){1'b0}}, cfg.threshold});
        tneg = -tpos;

        kind    = KIND_UP;
        crossed = 1'b1;
        if (p_w > tpos && v_w < tneg)
        begin
            kind = KIND_DOUBLE_UP;
        end
        else if (p_w < tneg && v_w > tpos)
        begin
            kind = KIND_DOUBLE_DOWN;
        end
        else if ((v_w > tpos && p_w < tpos) || (v_w < tpos && p_w > tpos))
        begin
            // a fall below the positive level counts as up too
            kind = KIND_UP;
        end
        else if ((v_w < tneg && p_w > tneg) || (v_w > tneg && p_w < tneg))
        begin
            kind = KIND_DOWN;
        end
        else
        begin
            crossed = 1'b0;
        end

        idx_ext = IDX_EXT'(ev.idx);
        idx10   = idx_ext[IDX_W-1:0];
        ts      = TS_W'(idx10) * TS_W'(cfg.time_per_sample);
        new_res = '{crossing_kind: kind, sample_index: idx10,
                    time_stamp: ts, last_result: 1'b0};
    end

    // release a held result once the next crossing or the item end shows up
    always_comb
    begin
        o_push             = 1'b0;
        o_data             = pend_item_reg;
        o_data.last_result = pend_done_reg || !crossed;
        if (pend_valid_reg)
        begin
            if (pend_done_reg)
            begin
                o_push = 1'b1;
            end
            else if (ev.valid && (crossed || ev.group_last))
            begin
                o_push = 1'b1;
            end
        end
        pend_valid_next = pend_valid_reg;
        pend_done_next  = pend_done_reg;
        pend_item_next  = pend_item_reg;
        if (ev.valid && crossed)
        begin
            pend_valid_next = 1'b1;
            pend_done_next  = ev.group_last;
            pend_item_next  = new_res;
        end
        else if (o_push)
        begin
            pend_valid_next = 1'b0;
            pend_done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_done_reg  <= 1'b0;
            prev_reg       <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_done_reg  <= pend_done_next;
            if (ev.valid)
            begin
                prev_reg <= v;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_item_reg <= pend_item_next;
    end

endmodule

`default_nettype wire
